FILE: hw/rtl/rcp_pkg.sv
// ----------------------------------------------------------------------------
// RESP command parser package
// Shared types, codes and constants of the RESP command parser.
// ----------------------------------------------------------------------------
package rcp_pkg;

  localparam int unsigned LenWidthDefault = 32;
  localparam int unsigned MaxBulksDefault = 255;

  localparam logic [7:0] CharStar   = 8'h2a;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharCr     = 8'h0d;
  localparam logic [7:0] CharLf     = 8'h0a;
  localparam logic [7:0] CharMinus  = 8'h2d;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_COUNT    = 3'd1,
    MODE_COUNT_CR = 3'd2,
    MODE_LEN      = 3'd3,
    MODE_LEN_CR   = 3'd4,
    MODE_DATA     = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ROLE_CMD  = 2'd0,
    ROLE_KEY  = 2'd1,
    ROLE_ARG  = 2'd2
  } role_e;

endpackage

FILE: hw/rtl/rcp_in_if.sv
// ----------------------------------------------------------------------------
// RESP command parser input channel
// Valid/ready channel that carries one byte of the request stream.
// ----------------------------------------------------------------------------
interface rcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

FILE: hw/rtl/rcp_out_if.sv
// ----------------------------------------------------------------------------
// RESP command parser output channel
// Valid/ready channel that carries one tagged result of the parser.
// ----------------------------------------------------------------------------
interface rcp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] role;
  logic [7:0] arg_index;
  logic [7:0] data_byte;
  logic       last_of_bulk;

  modport source (output valid, output kind, output role, output arg_index,
                  output data_byte, output last_of_bulk, input ready);
  modport sink   (input valid, input kind, input role, input arg_index,
                  input data_byte, input last_of_bulk, output ready);
endinterface

FILE: hw/rtl/resp_command_parser.sv
// ----------------------------------------------------------------------------
// RESP command parser
// Tags the payload bytes of RESP array-of-bulk-string requests.
// ----------------------------------------------------------------------------
// The parser takes one request byte per transaction and returns at most one
// tagged result for it: a command start for each '*' outside bulk data, every
// payload byte of a bulk string tagged as command name, key or numbered
// argument with its last byte marked, and one empty marker for a bulk of zero
// or negative length. It accepts a byte in every cycle unless the byte in the
// input register has a result while the output holds one not yet taken. A byte
// is held in an input register, the parse state is updated from it, and its
// result lands in an output register. The combinational state update, with
// the multiply-by-ten of the length field, sets the rate of one byte per cycle;
// the input keeps flowing while a result waits at the output as long as the
// waiting byte produces no result of its own.
module resp_command_parser #(
  parameter int unsigned LEN_WIDTH = rcp_pkg::LenWidthDefault,
  parameter int unsigned MAX_BULKS = rcp_pkg::MaxBulksDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rcp_in_if.sink   in_i,
  rcp_out_if.source out_o
);
  import rcp_pkg::*;

  localparam int unsigned WideWidth = LEN_WIDTH + 4;
  localparam logic [7:0]  MaxBulks  = 8'(MAX_BULKS);
  localparam logic [7:0]  ArgMax    = 8'(MAX_BULKS - 2);

  logic                 s1_valid_q;
  logic [7:0]           s1_byte_q;
  mode_e                mode_q, mode_d;
  logic [7:0]           bulk_q, bulk_d;
  logic [LEN_WIDTH-1:0] len_q, len_d;
  logic                 neg_q, neg_d;

  logic                 out_valid_q;
  kind_e                kind_q, kind_d;
  role_e                role_q, role_d;
  logic [7:0]           idx_q, idx_d;
  logic [7:0]           data_q, data_d;
  logic                 last_q, last_d;

  logic                 emit_w;
  logic                 adv_w;
  logic                 fire_w;
  logic [7:0]           b_w;
  logic [LEN_WIDTH-1:0] len_dec_w;
  logic                 data_last_w;
  logic [WideWidth-1:0] wide_w;
  logic [LEN_WIDTH-1:0] len_acc_w;
  logic                 is_digit_w;
  logic                 empty_w;
  logic [7:0]           bulk_inc_w;

  assign b_w         = s1_byte_q;
  assign len_dec_w   = (len_q != '0) ? len_q - LEN_WIDTH'(1) : len_q;
  assign data_last_w = (len_dec_w == '0);
  assign is_digit_w  = (b_w >= CharZero) && (b_w <= CharNine);
  assign wide_w      = ({4'b0, len_q} << 3) + ({4'b0, len_q} << 1)
                     + {{LEN_WIDTH{1'b0}}, b_w[3:0]};
  assign len_acc_w   = (wide_w[WideWidth-1:LEN_WIDTH] != '0) ? {LEN_WIDTH{1'b1}}
                                                           : wide_w[LEN_WIDTH-1:0];
  assign empty_w     = neg_q || (len_q == '0);
  assign bulk_inc_w  = (bulk_q < MaxBulks) ? bulk_q + 8'd1 : bulk_q;

  // Next parse state.
  always_comb begin
    mode_d = mode_q;
    bulk_d = bulk_q;
    len_d  = len_q;
    neg_d  = neg_q;
    if (mode_q == MODE_DATA) begin
      len_d = len_dec_w;
      if (data_last_w) begin
        bulk_d = bulk_inc_w;
        mode_d = MODE_IDLE;
      end
    end else if (b_w == CharStar) begin
      bulk_d = '0;
      len_d  = '0;
      neg_d  = 1'b0;
      mode_d = MODE_COUNT;
    end else if (b_w == CharDollar) begin
      len_d  = '0;
      neg_d  = 1'b0;
      mode_d = MODE_LEN;
    end else begin
      unique case (mode_q)
        MODE_COUNT: begin
          if (b_w == CharCr) mode_d = MODE_COUNT_CR;
        end
        MODE_COUNT_CR: begin
          if (b_w == CharLf) begin
            mode_d = MODE_IDLE;
          end else if (b_w != CharCr) begin
            mode_d = MODE_COUNT;
          end
        end
        MODE_LEN, MODE_LEN_CR: begin
          if ((mode_q == MODE_LEN_CR) && (b_w == CharLf)) begin
            neg_d = 1'b0;
            if (empty_w) begin
              len_d  = '0;
              bulk_d = bulk_inc_w;
              mode_d = MODE_IDLE;
            end else begin
              mode_d = MODE_DATA;
            end
          end else if (b_w == CharCr) begin
            mode_d = MODE_LEN_CR;
          end else begin
            mode_d = MODE_LEN;
            if (b_w == CharMinus) begin
              neg_d = 1'b1;
            end else if (is_digit_w) begin
              len_d = len_acc_w;
            end
          end
        end
        default: mode_d = MODE_IDLE;
      endcase
    end
  end

  // Result of the byte in the input register.
  always_comb begin
    emit_w = 1'b0;
    kind_d = KIND_CMD;
    data_d = '0;
    last_d = 1'b0;
    if (mode_q == MODE_DATA) begin
      emit_w = s1_valid_q;
      kind_d = KIND_DATA;
      data_d = b_w;
      last_d = data_last_w;
    end else if (b_w == CharStar) begin
      emit_w = s1_valid_q;
    end else if ((b_w != CharDollar) && (mode_q == MODE_LEN_CR) && (b_w == CharLf)
                 && empty_w) begin
      emit_w = s1_valid_q;
      kind_d = KIND_EMPTY;
      last_d = 1'b1;
    end
    role_d = ROLE_CMD;
    idx_d  = '0;
    if (kind_d != KIND_CMD) begin
      if (bulk_q == 8'd0) begin
        role_d = ROLE_CMD;
      end else if (bulk_q == 8'd1) begin
        role_d = ROLE_KEY;
      end else begin
        role_d = ROLE_ARG;
        idx_d  = ((bulk_q - 8'd2) > ArgMax) ? ArgMax : bulk_q - 8'd2;
      end
    end
  end

  assign adv_w      = !emit_w || !out_valid_q || out_o.ready;
  assign fire_w     = s1_valid_q && adv_w;
  assign in_i.ready = !s1_valid_q || adv_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      mode_q      <= MODE_IDLE;
      bulk_q      <= '0;
      len_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (fire_w) begin
        mode_q <= mode_d;
        bulk_q <= bulk_d;
        len_q  <= len_d;
        neg_q  <= neg_d;
      end
      if (fire_w && emit_w) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.stream_byte;
    end
    if (fire_w && emit_w) begin
      kind_q <= kind_d;
      role_q <= role_d;
      idx_q  <= idx_d;
      data_q <= data_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = kind_q;
  assign out_o.role         = role_q;
  assign out_o.arg_index    = idx_q;
  assign out_o.data_byte    = data_q;
  assign out_o.last_of_bulk = last_q;

  a_data_len_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_DATA) |-> (len_q != '0))
    else $error("Bulk data mode entered with no bytes left.");

  a_bulk_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bulk_q <= MaxBulks)
    else $error("Bulk count exceeded its saturation value.");

  a_cmd_start_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == KIND_CMD)) |-> ((role_q == ROLE_CMD) && !last_q))
    else $error("Command start carries a bulk role or last flag.");

  a_empty_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == KIND_EMPTY)) |-> (last_q && (data_q == 8'd0)))
    else $error("Empty marker is not flagged as last.");

  a_stall_holds_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv_w) |=> (s1_valid_q && $stable(s1_byte_q)))
    else $error("Stalled input byte was lost or overwritten.");

endmodule
